// ----- rtl/oam_pkg.sv -----
`default_nettype none

package oam_pkg;

    localparam int TIME_BITS_DEFAULT = 32;
    localparam int SPEED_W = 12;
    localparam int MS_W = 16;
    localparam int NOW_W = 32;
    localparam int EVENT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUTION_MARGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUTION_HYST = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCESS_HYST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_ENTER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_LEAVE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CAUTION_INTERVAL = 3'd6;

    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT = 12'd300;
    localparam logic [SPEED_W-1:0] RST_CAUTION_MARGIN = 12'd30;
    localparam logic [SPEED_W-1:0] RST_CAUTION_HYST = 12'd20;
    localparam logic [SPEED_W-1:0] RST_EXCESS_HYST = 12'd20;
    localparam logic [MS_W-1:0] RST_CONFIRM_ENTER = 16'd1000;
    localparam logic [MS_W-1:0] RST_CONFIRM_LEAVE = 16'd1500;
    localparam logic [MS_W-1:0] RST_CAUTION_INTERVAL = 16'd2500;

    localparam int EXCESS_BEEP_GAP_MS = 180;
    localparam int EXCESS_PAUSE_MS = 600;

    typedef enum logic [1:0] {
        LVL_NORMAL,
        LVL_CAUTION,
        LVL_EXCESS
    } level_t;

    typedef enum logic [2:0] {
        PK_NONE,
        PK_CAUTION,
        PK_EXCESS,
        PK_NORMAL,
        PK_LEAVE
    } pend_t;

    localparam logic [2:0] GPS_OK = 3'd0;
    localparam logic [2:0] GPS_NO_FRAMES = 3'd1;
    localparam logic [2:0] GPS_NO_RMC = 3'd2;
    localparam logic [2:0] GPS_NO_FIX = 3'd3;
    localparam logic [2:0] GPS_STALE = 3'd4;

    localparam logic [2:0] BEEP_NONE = 3'd0;
    localparam logic [2:0] BEEP_CAUTION = 3'd1;
    localparam logic [2:0] BEEP_EXCESS = 3'd2;
    localparam logic [2:0] BEEP_EVENT = 3'd3;
    localparam logic [2:0] BEEP_CLEAR = 3'd4;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               frames_seen;
        logic               rmc_seen;
        logic               fix_valid;
        logic               data_fresh;
        logic [NOW_W-1:0]   now_ms;
        logic               clear_count;
    } oam_item_t;

    typedef struct packed {
        logic [1:0]         speed_level;
        logic [2:0]         gps_status;
        logic [EVENT_W-1:0] event_count;
        logic               new_event;
        logic [2:0]         beep;
        logic               silence;
    } oam_res_t;

    typedef struct packed {
        logic [SPEED_W-1:0] limit;
        logic [SPEED_W-1:0] c_in;
        logic [SPEED_W-1:0] c_out;
        logic [SPEED_W-1:0] x_out;
        logic [MS_W-1:0]    enter_ms;
        logic [MS_W-1:0]    leave_ms;
        logic [MS_W-1:0]    interval_ms;
    } oam_thr_t;

endpackage

`default_nettype wire

// ----- rtl/oam_sample_if.sv -----
`default_nettype none

interface oam_sample_if;
    logic        valid;
    logic        ready;
    logic [11:0] speed;
    logic        frames_seen;
    logic        rmc_seen;
    logic        fix_valid;
    logic        data_fresh;
    logic [31:0] now_ms;
    logic        clear_count;

    modport source (
        output valid, speed, frames_seen, rmc_seen, fix_valid, data_fresh, now_ms,
               clear_count,
        input  ready
    );

    modport sink (
        input  valid, speed, frames_seen, rmc_seen, fix_valid, data_fresh, now_ms,
               clear_count,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/oam_result_if.sv -----
`default_nettype none

interface oam_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  speed_level;
    logic [2:0]  gps_status;
    logic [15:0] event_count;
    logic        new_event;
    logic [2:0]  beep;
    logic        silence;

    modport source (
        output valid, speed_level, gps_status, event_count, new_event, beep, silence,
        input  ready
    );

    modport sink (
        input  valid, speed_level, gps_status, event_count, new_event, beep, silence,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/oam_cfg.sv -----
`default_nettype none

module oam_cfg (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_we,
    input  wire  [oam_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire  [oam_pkg::CFG_DATA_W-1:0]       cfg_data,
    output oam_pkg::oam_thr_t                    thr
);
    import oam_pkg::*;

    logic [SPEED_W-1:0] limit_reg;
    logic [SPEED_W-1:0] margin_reg;
    logic [SPEED_W-1:0] c_hyst_reg;
    logic [SPEED_W-1:0] x_hyst_reg;
    logic [MS_W-1:0]    enter_reg;
    logic [MS_W-1:0]    leave_reg;
    logic [MS_W-1:0]    interval_reg;
    logic [SPEED_W-1:0] data12;
    logic [SPEED_W-1:0] c_in;

    assign data12 = cfg_data[SPEED_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= RST_SPEED_LIMIT;
            margin_reg   <= RST_CAUTION_MARGIN;
            c_hyst_reg   <= RST_CAUTION_HYST;
            x_hyst_reg   <= RST_EXCESS_HYST;
            enter_reg    <= RST_CONFIRM_ENTER;
            leave_reg    <= RST_CONFIRM_LEAVE;
            interval_reg <= RST_CAUTION_INTERVAL;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_LIMIT:
                begin
                    // A zero limit is rejected and the old limit stays.
                    if (data12 != '0)
                    begin
                        limit_reg <= data12;
                    end
                end
                CFG_CAUTION_MARGIN:   margin_reg   <= data12;
                CFG_CAUTION_HYST:     c_hyst_reg   <= data12;
                CFG_EXCESS_HYST:      x_hyst_reg   <= data12;
                CFG_CONFIRM_ENTER:    enter_reg    <= cfg_data[MS_W-1:0];
                CFG_CONFIRM_LEAVE:    leave_reg    <= cfg_data[MS_W-1:0];
                CFG_CAUTION_INTERVAL: interval_reg <= cfg_data[MS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign c_in = (limit_reg > margin_reg) ? limit_reg - margin_reg : '0;

    always_comb
    begin
        thr.limit       = limit_reg;
        thr.c_in        = c_in;
        thr.c_out       = (c_in > c_hyst_reg) ? c_in - c_hyst_reg : '0;
        thr.x_out       = (limit_reg > x_hyst_reg) ? limit_reg - x_hyst_reg : '0;
        thr.enter_ms    = enter_reg;
        thr.leave_ms    = leave_reg;
        thr.interval_ms = interval_reg;
    end

endmodule

`default_nettype wire

// ----- rtl/oam_eval.sv -----
`default_nettype none

module oam_eval #(
    parameter int TIME_BITS = oam_pkg::TIME_BITS_DEFAULT
) (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     go,
    input  wire oam_pkg::oam_item_t item,
    input  wire oam_pkg::oam_thr_t  thr,
    output oam_pkg::oam_res_t       res
);
    import oam_pkg::*;

    localparam logic [TIME_BITS-1:0] GAP_MS = TIME_BITS'(EXCESS_BEEP_GAP_MS);
    localparam logic [TIME_BITS-1:0] PAUSE_MS = TIME_BITS'(EXCESS_PAUSE_MS);

    level_t                level_reg, level_next;
    pend_t                 pend_reg, pend_next;
    logic [TIME_BITS-1:0]  pstart_reg, pstart_next;
    logic [TIME_BITS-1:0]  cl_beep_reg, cl_beep_next;
    logic                  cl_valid_reg, cl_valid_next;
    logic [TIME_BITS-1:0]  xl_beep_reg, xl_beep_next;
    logic [1:0]            xcnt_reg, xcnt_next;
    logic [EVENT_W-1:0]    events_reg, events_next;
    logic                  gok_reg, gok_next;

    logic [TIME_BITS-1:0]  now;
    logic [TIME_BITS-1:0]  el_pend;
    logic [TIME_BITS-1:0]  el_cl;
    logic [TIME_BITS-1:0]  el_xl;
    logic [TIME_BITS-1:0]  need_enter;
    logic [TIME_BITS-1:0]  need_leave;
    logic [TIME_BITS-1:0]  need_interval;
    logic [2:0]            status;
    logic                  caution;

    assign now           = item.now_ms[TIME_BITS-1:0];
    assign el_pend       = now - pstart_reg;
    assign el_cl         = now - cl_beep_reg;
    assign el_xl         = now - xl_beep_reg;
    assign need_enter    = TIME_BITS'(thr.enter_ms);
    assign need_leave    = TIME_BITS'(thr.leave_ms);
    assign need_interval = TIME_BITS'(thr.interval_ms);

    always_comb
    begin
        if (!item.frames_seen)
        begin
            status = GPS_NO_FRAMES;
        end
        else if (!item.rmc_seen)
        begin
            status = GPS_NO_RMC;
        end
        else if (!item.fix_valid)
        begin
            status = GPS_NO_FIX;
        end
        else if (!item.data_fresh)
        begin
            status = GPS_STALE;
        end
        else
        begin
            status = GPS_OK;
        end
    end

    always_comb
    begin
        level_next    = level_reg;
        pend_next     = pend_reg;
        pstart_next   = pstart_reg;
        cl_beep_next  = cl_beep_reg;
        cl_valid_next = cl_valid_reg;
        xl_beep_next  = xl_beep_reg;
        xcnt_next     = xcnt_reg;
        events_next   = events_reg;
        gok_next      = gok_reg;
        res           = '0;
        caution       = 1'b0;

        if (item.clear_count)
        begin
            events_next = '0;
            level_next  = LVL_NORMAL;
            pend_next   = PK_NONE;
            xcnt_next   = '0;
            res.beep    = BEEP_CLEAR;
        end

        if (status != GPS_OK)
        begin
            if (gok_reg)
            begin
                res.silence   = 1'b1;
                cl_beep_next  = '0;
                cl_valid_next = 1'b0;
                xl_beep_next  = '0;
                xcnt_next     = '0;
            end
            gok_next  = 1'b0;
            pend_next = PK_NONE;
        end
        else
        begin
            gok_next = 1'b1;
            if (level_next == LVL_EXCESS)
            begin
                if (item.speed < thr.x_out)
                begin
                    if (pend_next != PK_LEAVE)
                    begin
                        pend_next   = PK_LEAVE;
                        pstart_next = now;
                    end
                    else if (el_pend >= need_leave)
                    begin
                        level_next    = (item.speed < thr.c_out) ? LVL_NORMAL : LVL_CAUTION;
                        pend_next     = PK_NONE;
                        cl_beep_next  = '0;
                        cl_valid_next = 1'b0;
                        xl_beep_next  = '0;
                        xcnt_next     = '0;
                        res.silence   = 1'b1;
                    end
                end
                else
                begin
                    pend_next = PK_NONE;
                end
                if (level_next == LVL_EXCESS)
                begin
                    if (xcnt_next < 2'd2)
                    begin
                        if (el_xl > GAP_MS)
                        begin
                            res.beep     = BEEP_EXCESS;
                            xcnt_next    = xcnt_next + 2'd1;
                            xl_beep_next = now;
                        end
                    end
                    else if (el_xl > PAUSE_MS)
                    begin
                        xcnt_next    = '0;
                        xl_beep_next = now;
                    end
                end
            end
            else
            begin
                caution = (level_next == LVL_CAUTION);
                if (item.speed > thr.limit)
                begin
                    if (pend_next != PK_EXCESS)
                    begin
                        pend_next   = PK_EXCESS;
                        pstart_next = now;
                    end
                    else if (el_pend >= need_enter)
                    begin
                        level_next    = LVL_EXCESS;
                        pend_next     = PK_NONE;
                        cl_beep_next  = '0;
                        cl_valid_next = 1'b0;
                        xl_beep_next  = '0;
                        xcnt_next     = '0;
                        events_next   = events_next + 1'b1;
                        res.new_event = 1'b1;
                        res.beep      = BEEP_EVENT;
                    end
                end
                else if (!caution && item.speed >= thr.c_in)
                begin
                    if (pend_next != PK_CAUTION)
                    begin
                        pend_next   = PK_CAUTION;
                        pstart_next = now;
                    end
                    else if (el_pend >= need_enter)
                    begin
                        level_next    = LVL_CAUTION;
                        pend_next     = PK_NONE;
                        cl_beep_next  = '0;
                        cl_valid_next = 1'b0;
                        xl_beep_next  = '0;
                        xcnt_next     = '0;
                    end
                end
                else if (caution && item.speed < thr.c_out)
                begin
                    if (pend_next != PK_NORMAL)
                    begin
                        pend_next   = PK_NORMAL;
                        pstart_next = now;
                    end
                    else if (el_pend >= need_leave)
                    begin
                        level_next    = LVL_NORMAL;
                        pend_next     = PK_NONE;
                        cl_beep_next  = '0;
                        cl_valid_next = 1'b0;
                        xl_beep_next  = '0;
                        xcnt_next     = '0;
                        res.silence   = 1'b1;
                    end
                end
                else
                begin
                    pend_next = PK_NONE;
                end
                if (caution && level_next == LVL_CAUTION)
                begin
                    if (!cl_valid_reg || el_cl >= need_interval)
                    begin
                        res.beep      = BEEP_CAUTION;
                        cl_beep_next  = now;
                        cl_valid_next = 1'b1;
                    end
                end
            end
        end

        res.speed_level = level_next;
        res.gps_status  = status;
        res.event_count = events_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= LVL_NORMAL;
            pend_reg     <= PK_NONE;
            pstart_reg   <= '0;
            cl_beep_reg  <= '0;
            cl_valid_reg <= 1'b0;
            xl_beep_reg  <= '0;
            xcnt_reg     <= '0;
            events_reg   <= '0;
            gok_reg      <= 1'b0;
        end
        else if (go)
        begin
            level_reg    <= level_next;
            pend_reg     <= pend_next;
            pstart_reg   <= pstart_next;
            cl_beep_reg  <= cl_beep_next;
            cl_valid_reg <= cl_valid_next;
            xl_beep_reg  <= xl_beep_next;
            xcnt_reg     <= xcnt_next;
            events_reg   <= events_next;
            gok_reg      <= gok_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/overspeed_alarm_monitor.sv -----
// Channel   Direction  Handshake      Carries
// sample    in         valid/ready    speed, GPS flags, now_ms, clear_count
// result    out        valid/ready    speed_level, gps_status, event_count, beep, ...
// cfg       in         cfg_we         cfg_index, cfg_data (write only)
//
// Each request is registered on acceptance and evaluated once the output register is free or
// read, when its result is loaded into it. One request is taken every cycle while the result
// is not stalled. The level machine and its timers update in that same evaluation cycle. A
// stalled result holds the output register, and the input register then fills and drops
// ready. Reset restores the default thresholds and clears all alarm state.
`default_nettype none

module overspeed_alarm_monitor #(
    parameter int TIME_BITS = oam_pkg::TIME_BITS_DEFAULT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    oam_sample_if.sink                     sample,
    oam_result_if.source                   result,
    input  wire                            cfg_we,
    input  wire  [oam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [oam_pkg::CFG_DATA_W-1:0] cfg_data
);
    import oam_pkg::*;

    oam_item_t item_reg;
    logic      item_valid_reg;
    oam_res_t  res_reg;
    logic      res_valid_reg;
    oam_res_t  res_next;
    oam_thr_t  thr;
    logic      advance;
    logic      take;

    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign sample.ready = !item_valid_reg || advance;
    assign take         = sample.valid && sample.ready;

    oam_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    oam_eval #(
        .TIME_BITS (TIME_BITS)
    ) u_eval (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .item  (item_reg),
        .thr   (thr),
        .res   (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.speed       <= sample.speed;
            item_reg.frames_seen <= sample.frames_seen;
            item_reg.rmc_seen    <= sample.rmc_seen;
            item_reg.fix_valid   <= sample.fix_valid;
            item_reg.data_fresh  <= sample.data_fresh;
            item_reg.now_ms      <= sample.now_ms;
            item_reg.clear_count <= sample.clear_count;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.speed_level = res_reg.speed_level;
    assign result.gps_status  = res_reg.gps_status;
    assign result.event_count = res_reg.event_count;
    assign result.new_event   = res_reg.new_event;
    assign result.beep        = res_reg.beep;
    assign result.silence     = res_reg.silence;

endmodule

`default_nettype wire
